/* sv/mov_instruction_byte_decoder_macros.svh */
// Assertion macros for the MOV instruction byte decoder.
`ifndef MOV_INSTRUCTION_BYTE_DECODER_MACROS_SVH
`define MOV_INSTRUCTION_BYTE_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define MOVBD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MOVBD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define MOVBD_ASSERT_SAME(label, ante, cons)
`define MOVBD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* sv/movbd_pkg.sv */
// Types, codes and decode helpers for the MOV instruction byte decoder.
package movbd_pkg;

   typedef logic [1:0] status_type;
   typedef logic [2:0] form_type;

   localparam status_type STATUS_DECODED     = 2'd0;
   localparam status_type STATUS_UNSUPPORTED = 2'd1;
   localparam status_type STATUS_UNEXPECTED  = 2'd2;

   localparam form_type FORM_ACC_LOAD  = 3'd0;
   localparam form_type FORM_ACC_STORE = 3'd1;
   localparam form_type FORM_IMM_REG   = 3'd2;
   localparam form_type FORM_IMM_RM    = 3'd3;
   localparam form_type FORM_REG_RM    = 3'd4;
   localparam form_type FORM_NONE      = 3'd7;

   localparam logic [7:0] OP_ACC_LOAD  = 8'hA1;
   localparam logic [7:0] OP_ACC_STORE = 8'hA3;
   localparam logic [7:0] OP_IMM_REG_LO = 8'hB0;
   localparam logic [7:0] OP_IMM_REG_HI = 8'hBF;
   localparam logic [7:0] OP_IMM_RM_B  = 8'hC6;
   localparam logic [7:0] OP_IMM_RM_W  = 8'hC7;
   localparam logic [7:0] OP_REG_RM_LO = 8'h88;
   localparam logic [7:0] OP_REG_RM_HI = 8'h8B;

   localparam logic [1:0] MOD_NO_DISP  = 2'd0;
   localparam logic [1:0] MOD_DISP8    = 2'd1;
   localparam logic [1:0] MOD_DISP16   = 2'd2;
   localparam logic [1:0] MOD_REGISTER = 2'd3;
   localparam logic [2:0] RM_DIRECT    = 3'b110;

   function automatic form_type form_of(input logic [7:0] op);
      form_type f;
      f = FORM_NONE;
      if (op == OP_ACC_LOAD) f = FORM_ACC_LOAD;
      else if (op == OP_ACC_STORE) f = FORM_ACC_STORE;
      else if (op inside {[OP_IMM_REG_LO:OP_IMM_REG_HI]}) f = FORM_IMM_REG;
      else if (op inside {OP_IMM_RM_B, OP_IMM_RM_W}) f = FORM_IMM_RM;
      else if (op inside {[OP_REG_RM_LO:OP_REG_RM_HI]}) f = FORM_REG_RM;
      return f;
   endfunction

   // Displacement length in bytes (0, 1 or 2).
   function automatic logic [1:0] disp_len(input logic [7:0] op, input logic [7:0] modrm);
      form_type   f;
      logic [1:0] md;
      logic [1:0] len;
      f   = form_of(op);
      md  = modrm[7:6];
      len = 2'd0;
      if (f == FORM_ACC_LOAD || f == FORM_ACC_STORE) len = 2'd2;
      else if (f == FORM_IMM_RM || f == FORM_REG_RM) begin
         if (md == MOD_DISP8) len = 2'd1;
         else if (md == MOD_DISP16 || (md == MOD_NO_DISP && modrm[2:0] == RM_DIRECT))
            len = 2'd2;
      end
      return len;
   endfunction

   // Immediate length in bytes (0, 1 or 2).
   function automatic logic [1:0] imm_len(input logic [7:0] op);
      form_type   f;
      logic [1:0] len;
      f   = form_of(op);
      len = 2'd0;
      if (f == FORM_IMM_REG) len = op[3] ? 2'd2 : 2'd1;
      else if (f == FORM_IMM_RM) len = op[0] ? 2'd2 : 2'd1;
      return len;
   endfunction

endpackage

/* sv/mov_instruction_byte_decoder.sv */
// MOV instruction byte decoder: phase tracking, field gathering and result register.
// A result appears in the cycle after the byte that completes or ends an instruction.
// One code byte is taken per cycle unless a held result stalls the input; the phase update
// and field decode sit between the input handshake and the result register.
// A held result stalls the input only while the result side withholds ready.
// Synchronous active-high reset returns to awaiting an opcode and empties the result register.
`include "mov_instruction_byte_decoder_macros.svh"

module mov_instruction_byte_decoder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_code_byte,
   input  logic                     req_last_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output movbd_pkg::status_type    rsp_status,
   output movbd_pkg::form_type      rsp_form,
   output logic [7:0]               rsp_opcode_byte,
   output logic                     rsp_wide,
   output logic                     rsp_direction,
   output logic [1:0]               rsp_mode,
   output logic [2:0]               rsp_reg_index,
   output logic [2:0]               rsp_rm_index,
   output logic signed [15:0]       rsp_displacement,
   output logic signed [15:0]       rsp_immediate,
   output logic [15:0]              rsp_direct_address
);
   import movbd_pkg::*;

   typedef enum logic [2:0] {
      PH_OPCODE  = 3'd0,
      PH_MODRM   = 3'd1,
      PH_DISP_LO = 3'd2,
      PH_DISP_HI = 3'd3,
      PH_IMM_LO  = 3'd4,
      PH_IMM_HI  = 3'd5
   } phase_type;

   phase_type   phase_ff, next_phase, after_disp;
   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  modrm_ff, modrm_in;
   logic [15:0] disp_ff, disp_in;
   logic [15:0] imm_ff, imm_in;
   logic        unsupported;
   logic        done;
   logic        produce;
   logic        accept;
   form_type    form_in;

   logic               rsp_valid_ff;
   status_type         status_ff, status_in;
   form_type           form_ff, form_out_in;
   logic [7:0]         opcode_out_ff, opcode_out_in;
   logic               wide_ff, wide_in;
   logic               direction_ff, direction_in;
   logic [1:0]         mode_ff, mode_in;
   logic [2:0]         reg_ff, reg_in;
   logic [2:0]         rm_ff, rm_in;
   logic [15:0]        disp_out_ff, disp_out_in;
   logic [15:0]        imm_out_ff, imm_out_in;
   logic [15:0]        addr_ff, addr_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Phase advance and field gathering for the incoming byte.
   always_comb begin
      opcode_in   = opcode_ff;
      modrm_in    = modrm_ff;
      disp_in     = disp_ff;
      imm_in      = imm_ff;
      unsupported = 1'b0;
      next_phase  = PH_OPCODE;
      after_disp  = (imm_len(opcode_ff) != 2'd0) ? PH_IMM_LO : PH_OPCODE;
      case (phase_ff)
         PH_MODRM: begin
            modrm_in = req_code_byte;
            if (disp_len(opcode_ff, req_code_byte) != 2'd0) next_phase = PH_DISP_LO;
            else next_phase = after_disp;
         end
         PH_DISP_LO: begin
            if (disp_len(opcode_ff, modrm_ff) == 2'd2) begin
               disp_in    = {8'h00, req_code_byte};
               next_phase = PH_DISP_HI;
            end else begin
               disp_in    = {{8{req_code_byte[7]}}, req_code_byte};
               next_phase = after_disp;
            end
         end
         PH_DISP_HI: begin
            disp_in    = {req_code_byte, disp_ff[7:0]};
            next_phase = after_disp;
         end
         PH_IMM_LO: begin
            if (imm_len(opcode_ff) == 2'd2) begin
               imm_in     = {8'h00, req_code_byte};
               next_phase = PH_IMM_HI;
            end else begin
               imm_in     = {{8{req_code_byte[7]}}, req_code_byte};
               next_phase = PH_OPCODE;
            end
         end
         PH_IMM_HI: begin
            imm_in     = {req_code_byte, imm_ff[7:0]};
            next_phase = PH_OPCODE;
         end
         default: begin
            // The opcode phase and unused phase codes fall here and start a new instruction.
            opcode_in = req_code_byte;
            modrm_in  = 8'h00;
            disp_in   = 16'h0000;
            imm_in    = 16'h0000;
            case (form_of(req_code_byte))
               FORM_IMM_RM, FORM_REG_RM: next_phase = PH_MODRM;
               FORM_IMM_REG:             next_phase = PH_IMM_LO;
               FORM_ACC_LOAD, FORM_ACC_STORE: next_phase = PH_DISP_LO;
               default:                  unsupported = 1'b1;
            endcase
         end
      endcase
   end

   assign done    = !unsupported && (next_phase == PH_OPCODE);
   assign produce = unsupported || done || req_last_byte;
   assign form_in = form_of(opcode_in);

   // Result fields built from the updated instruction state.
   always_comb begin
      status_in     = STATUS_DECODED;
      form_out_in   = '0;
      opcode_out_in = opcode_in;
      wide_in       = 1'b0;
      direction_in  = 1'b0;
      mode_in       = '0;
      reg_in        = '0;
      rm_in         = '0;
      disp_out_in   = '0;
      imm_out_in    = '0;
      addr_in       = '0;
      if (unsupported) begin
         status_in = STATUS_UNSUPPORTED;
      end else if (!done) begin
         status_in   = STATUS_UNEXPECTED;
         form_out_in = form_in;
      end else begin
         form_out_in = form_in;
         case (form_in)
            FORM_ACC_LOAD, FORM_ACC_STORE: begin
               wide_in      = 1'b1;
               direction_in = (form_in == FORM_ACC_LOAD);
               addr_in      = disp_in;
            end
            FORM_IMM_REG: begin
               wide_in      = opcode_in[3];
               direction_in = 1'b1;
               mode_in      = MOD_REGISTER;
               reg_in       = opcode_in[2:0];
               imm_out_in   = imm_in;
            end
            default: begin
               wide_in      = opcode_in[0];
               direction_in = (form_in == FORM_REG_RM) ? opcode_in[1] : 1'b0;
               mode_in      = modrm_in[7:6];
               reg_in       = modrm_in[5:3];
               rm_in        = modrm_in[2:0];
               disp_out_in  = disp_in;
               imm_out_in   = (form_in == FORM_IMM_RM) ? imm_in : 16'h0000;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPCODE;
         opcode_ff    <= 8'h00;
         modrm_ff     <= 8'h00;
         disp_ff      <= 16'h0000;
         imm_ff       <= 16'h0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= produce ? PH_OPCODE : next_phase;
            opcode_ff <= opcode_in;
            modrm_ff  <= modrm_in;
            disp_ff   <= disp_in;
            imm_ff    <= imm_in;
         end
         // Hold a result until taken; load a fresh one when this byte closes out an instruction.
         if (accept && produce) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && produce) begin
         status_ff     <= status_in;
         form_ff       <= form_out_in;
         opcode_out_ff <= opcode_out_in;
         wide_ff       <= wide_in;
         direction_ff  <= direction_in;
         mode_ff       <= mode_in;
         reg_ff        <= reg_in;
         rm_ff         <= rm_in;
         disp_out_ff   <= disp_out_in;
         imm_out_ff    <= imm_out_in;
         addr_ff       <= addr_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_form           = form_ff;
   assign rsp_opcode_byte    = opcode_out_ff;
   assign rsp_wide           = wide_ff;
   assign rsp_direction      = direction_ff;
   assign rsp_mode           = mode_ff;
   assign rsp_reg_index      = reg_ff;
   assign rsp_rm_index       = rm_ff;
   assign rsp_displacement   = disp_out_ff;
   assign rsp_immediate      = imm_out_ff;
   assign rsp_direct_address = addr_ff;

   `MOVBD_ASSERT_SAME(a_ready_when_empty, !rsp_valid_ff, req_ready)
   `MOVBD_ASSERT_NEXT(a_last_byte_restarts, accept && req_last_byte, phase_ff == PH_OPCODE)
   `MOVBD_ASSERT_NEXT(a_result_follows_end, accept && req_last_byte, rsp_valid_ff)
   `MOVBD_ASSERT_SAME(a_unsup_clean, rsp_valid_ff && status_ff == STATUS_UNSUPPORTED, form_ff == '0)
   `MOVBD_ASSERT_SAME(a_acc_load_fixed, done && form_in == FORM_ACC_LOAD, wide_in && direction_in)

endmodule
